>>> design/lrbe_pkg.sv
// package for the longest-run-between-extremes block
// holds default sizes and output field widths; no dependencies
package lrbe_pkg;

    localparam int unsigned MAX_LENGTH_DEF  = 16384;
    localparam int unsigned SAMPLE_BITS_DEF = 32;

    // result index fields carry the low bits of an index
    localparam int unsigned IDX_OUT_W  = 14;
    localparam int unsigned OUT_DATA_W = ((3 * IDX_OUT_W + 7) / 8) * 8;

endpackage

>>> design/longest_run_between_extremes.sv
// top level of the longest-run-between-extremes block
// depends on lrbe_pkg for defaults and output field widths
//
//  channel   dir   tdata (low bit up)                              tuser      tlast
//  s_axis    in    sample (SAMPLE_BITS, signed), zero pad to byte  -          is_last
//  m_axis    out   first_extreme(14), second_extreme(14),          overflow   -
//                  distance(14), zero pad to 48
//
// one sample per cycle sustained while no last sample waits on a stalled result;
// a sample is held in the input register, then the run tracker updates and, on the
// last sample, loads the result register, whose valid flag drives o_m_axis_tvalid
// synchronous active-low reset clears all trend/run state and both valid flags
// a stalled result holds back only the next last sample and the input behind it
module longest_run_between_extremes #(
    parameter int unsigned MAX_LENGTH  = lrbe_pkg::MAX_LENGTH_DEF,
    parameter int unsigned SAMPLE_BITS = lrbe_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                           i_clk,
    input  logic                                           i_rst_n,
    input  logic                                           i_s_axis_tvalid,
    output logic                                           o_s_axis_tready,
    input  logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0]       i_s_axis_tdata,  // sample
    input  logic                                           i_s_axis_tlast,  // is_last
    output logic                                           o_m_axis_tvalid,
    input  logic                                           i_m_axis_tready,
    // first_extreme, second_extreme, distance
    output logic [lrbe_pkg::OUT_DATA_W-1:0]                o_m_axis_tdata,
    output logic                                           o_m_axis_tuser   // overflow
);
    import lrbe_pkg::*;

    localparam int unsigned IDX_W = $clog2(MAX_LENGTH);
    localparam int unsigned CNT_W = $clog2(MAX_LENGTH + 1);
    localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_LENGTH);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_LENGTH - 1);

    // input register
    logic                          r_in_valid;
    logic signed [SAMPLE_BITS-1:0] r_in_sample;
    logic                          r_in_last;

    // run tracking state
    logic signed [SAMPLE_BITS-1:0] r_prev, n_prev;
    logic [CNT_W-1:0]              r_count, n_count;
    logic                          r_falling, n_falling;
    logic [IDX_W-1:0]              r_run_start, n_run_start;
    logic [IDX_W-1:0]              r_best_start, n_best_start;
    logic [IDX_W-1:0]              r_best_end, n_best_end;
    logic                          r_exceeded, n_exceeded;

    // result register
    logic                          r_out_valid;
    logic [IDX_W-1:0]              r_res_start, n_res_start;
    logic [IDX_W-1:0]              r_res_end, n_res_end;
    logic                          r_res_ovf, n_res_ovf;

    logic             fire;
    logic             out_free;
    logic [IDX_W-1:0] k_idx;
    logic [IDX_W-1:0] last_idx;
    logic             turn;

    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign fire            = r_in_valid && (!r_in_last || out_free);
    assign o_s_axis_tready = !r_in_valid || fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_sample <= i_s_axis_tdata[SAMPLE_BITS-1:0];
            r_in_last   <= i_s_axis_tlast;
        end
    end

    always_comb begin
        n_prev       = r_prev;
        n_count      = r_count;
        n_falling    = r_falling;
        n_run_start  = r_run_start;
        n_best_start = r_best_start;
        n_best_end   = r_best_end;
        n_exceeded   = r_exceeded;
        n_res_start  = r_res_start;
        n_res_end    = r_res_end;
        n_res_ovf    = r_res_ovf;
        k_idx        = r_count[IDX_W-1:0];
        last_idx     = k_idx;
        turn         = 1'b0;

        if (r_count == CNT_MAX) begin
            // samples past the limit only mark the overflow
            n_exceeded = 1'b1;
            last_idx   = IDX_LAST;
        end else begin
            if (r_count == CNT_W'(1)) begin
                n_falling = r_prev > r_in_sample;
            end else if (r_count != '0) begin
                turn = (r_falling && (r_prev < r_in_sample)) ||
                       (!r_falling && (r_prev > r_in_sample));
            end
            if (turn) begin
                n_falling = !r_falling;
                // close the run ending at the previous sample
                if ((k_idx - IDX_W'(1)) - r_run_start > r_best_end - r_best_start) begin
                    n_best_start = r_run_start;
                    n_best_end   = k_idx - IDX_W'(1);
                end
                n_run_start = k_idx - IDX_W'(1);
            end
            n_prev  = r_in_sample;
            n_count = r_count + CNT_W'(1);
        end

        if (r_in_last) begin
            // the open run competes too
            if (last_idx - n_run_start > n_best_end - n_best_start) begin
                n_best_start = n_run_start;
                n_best_end   = last_idx;
            end
            n_res_start  = n_best_start;
            n_res_end    = n_best_end;
            n_res_ovf    = n_exceeded;
            n_prev       = '0;
            n_count      = '0;
            n_falling    = 1'b0;
            n_run_start  = '0;
            n_best_start = '0;
            n_best_end   = '0;
            n_exceeded   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev       <= '0;
            r_count      <= '0;
            r_falling    <= 1'b0;
            r_run_start  <= '0;
            r_best_start <= '0;
            r_best_end   <= '0;
            r_exceeded   <= 1'b0;
        end else if (fire) begin
            r_prev       <= n_prev;
            r_count      <= n_count;
            r_falling    <= n_falling;
            r_run_start  <= n_run_start;
            r_best_start <= n_best_start;
            r_best_end   <= n_best_end;
            r_exceeded   <= n_exceeded;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && r_in_last) begin
            r_res_start <= n_res_start;
            r_res_end   <= n_res_end;
            r_res_ovf   <= n_res_ovf;
        end
    end

    // fit indices to the fixed output field width
    logic [IDX_W+IDX_OUT_W-1:0] wide_start;
    logic [IDX_W+IDX_OUT_W-1:0] wide_end;
    logic [IDX_W+IDX_OUT_W-1:0] wide_dist;

    assign wide_start = {{IDX_OUT_W{1'b0}}, r_res_start};
    assign wide_end   = {{IDX_OUT_W{1'b0}}, r_res_end};
    assign wide_dist  = {{IDX_OUT_W{1'b0}}, r_res_end - r_res_start};

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_res_ovf;
    assign o_m_axis_tdata  = OUT_DATA_W'({wide_dist[IDX_OUT_W-1:0],
                                          wide_end[IDX_OUT_W-1:0],
                                          wide_start[IDX_OUT_W-1:0]});

endmodule

>>> design/lrbe_checker.sv
// port-level checks for longest_run_between_extremes
// depends on lrbe_pkg; bound to the top level at the end of this file
module lrbe_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_s_axis_tvalid,
    input logic                            o_s_axis_tready,
    input logic                            i_s_axis_tlast,   // is_last
    input logic                            o_m_axis_tvalid,
    input logic                            i_m_axis_tready,
    // first_extreme, second_extreme, distance
    input logic [lrbe_pkg::OUT_DATA_W-1:0] o_m_axis_tdata,
    input logic                            o_m_axis_tuser    // overflow
);
    import lrbe_pkg::*;

    logic [IDX_OUT_W-1:0] first_x;
    logic [IDX_OUT_W-1:0] second_x;
    logic [IDX_OUT_W-1:0] span_x;

    assign first_x  = o_m_axis_tdata[IDX_OUT_W-1:0];
    assign second_x = o_m_axis_tdata[2*IDX_OUT_W-1:IDX_OUT_W];
    assign span_x   = o_m_axis_tdata[3*IDX_OUT_W-1:2*IDX_OUT_W];

    // a stalled word holds valid and payload
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $past(o_m_axis_tvalid) && !$past(i_m_axis_tready) |->
        o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("result word changed while stalled");

    a_dist: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> span_x == IDX_OUT_W'(second_x - first_x))
        else $error("distance does not match the extremes");

    // no result word in the cycle after a reset edge
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid right after reset");

    a_needs_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) && $past(i_rst_n, 2) |->
        $past(i_s_axis_tvalid && o_s_axis_tready && i_s_axis_tlast, 2) ||
        !$past(o_s_axis_tready))
        else $error("result appeared without a last sample");

endmodule

bind longest_run_between_extremes lrbe_checker u_lrbe_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tlast  (i_s_axis_tlast),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);
